// ===== hw/rtl/lpr_pkg.sv =====
package lpr_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_FRAMES_DEF = 8;
	localparam int PAGE_BITS_DEF  = 16;

	// Fixed field widths
	localparam int CFG_W     = 4;
	localparam int SLOT_OUT_W = 3;
	localparam int FAULT_W   = 32;

	localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = CFG_W'(8);

	// Sequencer states, one-hot
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_UPD   = 4'b1000
	} lpr_state_t;

endpackage

// ===== hw/rtl/lpr_page_mem.sv =====
module lpr_page_mem
	import lpr_pkg::*;
#(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF,
	localparam int SLOT_W    = $clog2(MAX_FRAMES)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [SLOT_W-1:0]    wr_addr,
	input  logic [PAGE_BITS-1:0] wr_data,
	input  logic                 rd_en,
	input  logic [SLOT_W-1:0]    rd_addr,
	output logic [PAGE_BITS-1:0] rd_data
);

	logic [PAGE_BITS-1:0] mem [MAX_FRAMES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/lpr_rank_file.sv =====
module lpr_rank_file
	import lpr_pkg::*;
#(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF,
	localparam int SLOT_W    = $clog2(MAX_FRAMES),
	localparam int FILL_W    = $clog2(MAX_FRAMES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	// single read port
	input  logic [SLOT_W-1:0] rd_sel,
	output logic [SLOT_W-1:0] rd_rank,
	// touch: make slot most recent, age younger filled slots
	input  logic              touch_en,
	input  logic [SLOT_W-1:0] touch_slot,
	input  logic [SLOT_W-1:0] touch_old_rank,
	input  logic [FILL_W-1:0] filled
);

	logic [SLOT_W-1:0] rank_q [MAX_FRAMES];

	assign rd_rank = rank_q[rd_sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (touch_en) begin
			for (int i = 0; i < MAX_FRAMES; i++) begin
				if (SLOT_W'(i) == touch_slot) begin
					rank_q[i] <= '0;
				end else if (FILL_W'(i) < filled && rank_q[i] < touch_old_rank) begin
					rank_q[i] <= rank_q[i] + SLOT_W'(1);
				end
			end
		end
	end

endmodule

// ===== hw/rtl/lru_page_replacement.sv =====
// LRU page replacement unit.
//
// Request channel: in_valid / in_stall carry one page number per request.
// The unit drives in_stall high while a request is being worked on and takes
// the next one only once the previous result sits in the output register.
// Result channel: out_valid / out_stall carry hit, slot, evicted_valid,
// evicted_page and fault_count. A result waits in the output register while
// out_stall is high; the unit keeps scanning the next request meanwhile and
// holds its final update until the output register is free.
// Timing: resident pages live in a one-read-port page memory that is scanned
// one slot per cycle. An accepted request passes through the read state, one
// drain state and the update state, which writes the output register; with no
// slot filled it goes straight to the update state. Ranks sit in flip-flops
// next to the scan and are all updated together in the update state.
// Configuration: cfg_we writes frames_in_use from cfg_wdata; 0 acts as 1 and
// values above MAX_FRAMES act as MAX_FRAMES. Write it only while idle.
// Reset (arst_n low): no slot filled, fault count zero, frames_in_use = 8,
// no result pending. No clearing pass is needed; page memory is read only at
// filled slots.
module lru_page_replacement
	import lpr_pkg::*;
#(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_wdata,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PAGE_BITS-1:0]  page,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  hit,
	output logic [SLOT_OUT_W-1:0] slot,
	output logic                  evicted_valid,
	output logic [PAGE_BITS-1:0]  evicted_page,
	output logic [FAULT_W-1:0]    fault_count
);

	localparam int SLOT_W = $clog2(MAX_FRAMES);
	localparam int FILL_W = $clog2(MAX_FRAMES + 1);
	localparam int CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

	lpr_state_t state_q;

	logic [CFG_W-1:0]     frames_in_use_q;
	logic [FILL_W-1:0]    filled_q;
	logic [FAULT_W-1:0]   faults_q;

	// request being worked on
	logic [PAGE_BITS-1:0] page_q;
	logic [SLOT_W-1:0]    idx_q;
	logic                 hit_q;
	logic [SLOT_W-1:0]    hit_slot_q;
	logic [SLOT_W-1:0]    hit_rank_q;
	logic [SLOT_W-1:0]    lru_slot_q;
	logic [PAGE_BITS-1:0] ev_page_q;

	// compare stage behind the memory read
	logic                 rd_v_s1;
	logic [SLOT_W-1:0]    rd_idx_s1;

	// output register
	logic                  out_valid_q;
	logic                  hit_o_q;
	logic [SLOT_OUT_W-1:0] slot_o_q;
	logic                  ev_valid_o_q;
	logic [PAGE_BITS-1:0]  ev_page_o_q;
	logic [FAULT_W-1:0]    fault_o_q;

	logic                 in_acc;
	logic                 out_acc;
	logic                 commit;
	logic                 rd_en;
	logic                 last_rd;
	logic [PAGE_BITS-1:0] rd_data;
	logic [SLOT_W-1:0]    rd_rank;
	logic [FILL_W-1:0]    filled_m1;
	logic [CMP_W-1:0]     cfg_x;
	logic [CMP_W-1:0]     lim_x;
	logic                 can_fill;
	logic                 do_fill;
	logic                 do_repl;
	logic [SLOT_W-1:0]    slot_sel;
	logic [SLOT_W-1:0]    old_rank;
	logic [FAULT_W-1:0]   faults_nx;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign commit   = (state_q == S_UPD) && (!out_valid_q || !out_stall);

	assign rd_en     = (state_q == S_READ);
	assign filled_m1 = filled_q - FILL_W'(1);
	assign last_rd   = (FILL_W'(idx_q) == filled_m1);

	// clamp frames_in_use to 1..MAX_FRAMES
	assign cfg_x = CMP_W'(frames_in_use_q);
	always_comb begin
		if (cfg_x == '0) begin
			lim_x = CMP_W'(1);
		end else if (cfg_x > CMP_W'(MAX_FRAMES)) begin
			lim_x = CMP_W'(MAX_FRAMES);
		end else begin
			lim_x = cfg_x;
		end
	end

	assign can_fill = CMP_W'(filled_q) < lim_x;
	assign do_fill  = !hit_q && can_fill;
	assign do_repl  = !hit_q && !can_fill;

	always_comb begin
		if (hit_q) begin
			slot_sel = hit_slot_q;
			old_rank = hit_rank_q;
		end else if (can_fill) begin
			slot_sel = SLOT_W'(filled_q);
			old_rank = SLOT_W'(filled_q);
		end else begin
			// full: the LRU slot holds the oldest rank
			slot_sel = lru_slot_q;
			old_rank = SLOT_W'(filled_m1);
		end
	end

	assign faults_nx = (!hit_q && faults_q != '1) ? faults_q + FAULT_W'(1) : faults_q;

	lpr_page_mem #(
		.MAX_FRAMES (MAX_FRAMES),
		.PAGE_BITS  (PAGE_BITS)
	) u_page_mem (
		.clk     (clk),
		.wr_en   (commit && !hit_q),
		.wr_addr (slot_sel),
		.wr_data (page_q),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	lpr_rank_file #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_rank_file (
		.clk            (clk),
		.arst_n         (arst_n),
		.rd_sel         (rd_idx_s1),
		.rd_rank        (rd_rank),
		.touch_en       (commit),
		.touch_slot     (slot_sel),
		.touch_old_rank (old_rank),
		.filled         (filled_q)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						idx_q   <= '0;
						state_q <= (filled_q == '0) ? S_UPD : S_READ;
					end
				end
				S_READ: begin
					idx_q <= idx_q + SLOT_W'(1);
					if (last_rd) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload and scan results
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (in_acc) begin
			page_q <= page;
		end
		if (rd_v_s1) begin
			if (rd_data == page_q) begin
				hit_slot_q <= rd_idx_s1;
				hit_rank_q <= rd_rank;
			end
			if (FILL_W'(rd_rank) == filled_m1) begin
				lru_slot_q <= rd_idx_s1;
				ev_page_q  <= rd_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (in_acc) begin
			hit_q <= 1'b0;
		end else if (rd_v_s1 && rd_data == page_q) begin
			hit_q <= 1'b1;
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= FRAMES_IN_USE_RST;
			filled_q        <= '0;
			faults_q        <= '0;
		end else begin
			if (cfg_we) begin
				frames_in_use_q <= cfg_wdata;
			end
			if (commit) begin
				faults_q <= faults_nx;
				if (do_fill) begin
					filled_q <= filled_q + FILL_W'(1);
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			hit_o_q      <= hit_q;
			slot_o_q     <= SLOT_OUT_W'(slot_sel);
			ev_valid_o_q <= do_repl;
			ev_page_o_q  <= do_repl ? ev_page_q : '0;
			fault_o_q    <= faults_nx;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_o_q;
	assign slot          = slot_o_q;
	assign evicted_valid = ev_valid_o_q;
	assign evicted_page  = ev_page_o_q;
	assign fault_count   = fault_o_q;

	// filled count never passes the built frame count
	a_filled_max: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= FILL_W'(MAX_FRAMES))
		else $error("filled count above MAX_FRAMES");

	// a miss below saturation bumps the fault count by exactly one
	a_fault_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && !hit_q && faults_q != '1) |=> faults_q == $past(faults_q) + FAULT_W'(1))
		else $error("fault count not incremented on miss");

	// an update never overwrites a result still waiting on the output
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !commit)
		else $error("result overwritten while stalled");

endmodule

// ===== verif/lru_page_replacement_tb.sv =====
`timescale 1ns / 1ps

module lru_page_replacement_tb;
	import lpr_pkg::*;

	localparam int FRAMES       = MAX_FRAMES_DEF;
	localparam int PG_W         = PAGE_BITS_DEF;
	localparam int QUIET_LIMIT  = 600;	// cycles with no request or result moving
	localparam int TAIL_CYCLES  = 24;
	localparam int PHASE_ITEMS  = 120;

	typedef struct packed {
		logic                  hit;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  ev_valid;
		logic [PG_W-1:0]       ev_page;
		logic [FAULT_W-1:0]    faults;
	} lookup_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_W-1:0]      cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [PG_W-1:0]       page = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  hit;
	logic [SLOT_OUT_W-1:0] slot;
	logic                  evicted_valid;
	logic [PG_W-1:0]       evicted_page;
	logic [FAULT_W-1:0]    fault_count;

	// shadow copy of the replacement state
	logic [PG_W-1:0]       shadow_page [FRAMES];
	int                    shadow_rank [FRAMES];
	int                    shadow_filled = 0;
	logic [FAULT_W-1:0]    shadow_faults = '0;
	logic [CFG_W-1:0]      shadow_frames = CFG_W'(8);

	lookup_t               lookup_q[$];
	int                    error_count = 0;
	int                    quiet_cycles = 0;
	int                    stall_pct = 0;
	int                    stall_run = 0;
	bit                    gaps_on = 1'b0;
	int                    burst_left = 0;

	lru_page_replacement #(
		.MAX_FRAMES(FRAMES),
		.PAGE_BITS (PG_W)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.page         (page),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.slot         (slot),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.fault_count  (fault_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// slot s becomes most recent; filled slots younger than its old rank age by one
	function automatic void make_recent(input int s, input int old_rank);
		for (int i = 0; i < shadow_filled; i++) begin
			if (i != s && shadow_rank[i] < old_rank)
				shadow_rank[i]++;
		end
		shadow_rank[s] = 0;
	endfunction

	function automatic lookup_t predict_lookup(input logic [PG_W-1:0] pg);
		lookup_t r;
		int      lim;
		int      s;
		int      prev;
		bit      found;
		r     = '0;
		s     = 0;
		found = 1'b0;
		lim   = (shadow_frames == 0) ? 1 :
			(int'(shadow_frames) > FRAMES) ? FRAMES : int'(shadow_frames);
		for (int i = 0; i < shadow_filled; i++) begin
			if (!found && shadow_page[i] == pg) begin
				found = 1'b1;
				s     = i;
			end
		end
		if (found) begin
			r.hit = 1'b1;
			make_recent(s, shadow_rank[s]);
		end else begin
			if (shadow_faults != '1)
				shadow_faults++;
			if (shadow_filled < lim) begin
				// fill the first free slot: oldest first, then most recent
				prev           = shadow_filled;
				s              = prev;
				shadow_page[s] = pg;
				shadow_filled  = prev + 1;
				shadow_rank[s] = prev;
				make_recent(s, prev);
			end else begin
				for (int i = 1; i < shadow_filled; i++) begin
					if (shadow_rank[i] > shadow_rank[s])
						s = i;
				end
				r.ev_valid     = 1'b1;
				r.ev_page      = shadow_page[s];
				shadow_page[s] = pg;
				make_recent(s, shadow_rank[s]);
			end
		end
		r.slot   = SLOT_OUT_W'(s);
		r.faults = shadow_faults;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
		error_count++;
	endtask

	// drive one request and hold it until taken
	task automatic send_request(input logic [PG_W-1:0] pg);
		in_valid <= 1'b1;
		page     <= pg;
		do
			@(posedge clk);
		while (in_stall);
		lookup_q = {lookup_q, predict_lookup(pg)};
		if (gaps_on) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat (($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) :
						$urandom_range(1, 4))
					@(posedge clk);
				burst_left = $urandom_range(1, 12);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (lookup_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_frames(input logic [CFG_W-1:0] v);
		drain_results();
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we        <= 1'b0;
		shadow_frames = v;
		@(posedge clk);
	endtask

	// zero frames acts as one: second distinct page evicts the first
	task automatic test_register_zero();
		write_frames(CFG_W'(0));
		send_request(16'h0000);
		send_request(16'hFFFF);
		send_request(16'hFFFF);
		send_request(16'h0000);
	endtask

	// above the built count acts as the built count; fill all, hit, then evict LRU
	task automatic test_register_over_max();
		logic [PG_W-1:0] seq[$] = '{16'hAAAA, 16'h5555, 16'h0001, 16'h8000,
			16'h1234, 16'h0F0F, 16'h7FFE, 16'hAAAA, 16'hC3C3, 16'hC3C3,
			16'h0000, 16'hFFFF};
		write_frames(CFG_W'(15));
		foreach (seq[i])
			send_request(seq[i]);
	endtask

	// residents survive a lower limit and still hit; misses replace LRU of all
	task automatic test_lowered_while_full();
		logic [PG_W-1:0] seq[$] = '{16'h5555, 16'h4242, 16'h9999, 16'h0F0F, 16'h4242};
		write_frames(CFG_W'(2));
		foreach (seq[i])
			send_request(seq[i]);
	endtask

	// mostly a small working set so hits and evictions mix, some wild pages
	task automatic test_random_traffic();
		int              plan[10] = '{8, 1, 3, 15, 5, 0, 2, 8, 7, 4};
		int              pcts[3]  = '{0, 25, 60};
		logic [PG_W-1:0] pool[16];
		int              pool_n;
		for (int ph = 0; ph < 10; ph++) begin
			write_frames(CFG_W'(plan[ph]));
			stall_pct = pcts[ph % 3];
			gaps_on   = (ph % 4 != 1);
			pool_n    = $urandom_range(3, 14);
			for (int k = 0; k < pool_n; k++)
				pool[k] = PG_W'($urandom_range(0, 65535));
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 9) < 8)
					send_request(pool[$urandom_range(0, pool_n - 1)]);
				else
					send_request(PG_W'($urandom_range(0, 65535)));
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (lookup_q.size() == 0) begin
				report_mismatch("result with nothing pending", fault_count, 0);
			end else begin
				want = lookup_q.pop_front();
				if (hit !== want.hit)
					report_mismatch("hit", 32'(hit), 32'(want.hit));
				if (slot !== want.slot)
					report_mismatch("slot", 32'(slot), 32'(want.slot));
				if (evicted_valid !== want.ev_valid)
					report_mismatch("evicted_valid", 32'(evicted_valid),
						32'(want.ev_valid));
				if (evicted_page !== want.ev_page)
					report_mismatch("evicted_page", 32'(evicted_page),
						32'(want.ev_page));
				if (fault_count !== want.faults)
					report_mismatch("fault_count", fault_count, want.faults);
			end
		end
	end

	// receiver stall pattern: runs of stall / no stall
	always @(posedge clk) begin
		if (stall_run != 0) begin
			stall_run <= stall_run - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
			stall_run <= $urandom_range(0, 7);
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		stall_pct = 30;
		gaps_on   = 1'b1;
		test_register_zero();
		test_register_over_max();
		test_lowered_while_full();
		test_random_traffic();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
